// ===== rtl/core/imhq_pkg.sv =====
// Package with the types, constants and sequencer states of the indexed min-heap queue.
package imhq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_BITS  = 32;
    localparam int HANDLES   = 1024;

    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int HANDLE_W  = $clog2(HANDLES);
    localparam int CHILD_W   = SLOT_W + 2;

    localparam logic [CNT_W-1:0]    NOT_IN_HEAP = CNT_W'(CAPACITY);
    localparam logic [KEY_BITS-1:0] KEY_INF     = '1;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_CHANGE = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_SLOT  = 2'd2
    } status_t;

    typedef struct packed {
        func_t                func;
        logic [SLOT_W-1:0]    slot;
        logic [KEY_BITS-1:0]  new_key;
        logic [HANDLE_W-1:0]  handle;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [KEY_BITS-1:0]  min_key;
        logic [HANDLE_W-1:0]  min_handle;
        logic [CNT_W-1:0]     entry_count;
        logic [CNT_W-1:0]     handle_slot;
    } out_item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [HANDLE_W-1:0]  owner;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_DECIDE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_PLACE,
        S_RD_OUT,
        S_OUT
    } state_t;

endpackage

// ===== rtl/core/indexed_min_heap_queue.sv =====
// Indexed binary min-heap priority queue with a handle-to-slot position table.
//
// One transaction is handled at a time. An insert, delete or change key walks the
// heap one level per step with a single entry memory port: a sift up reads and then
// compares the parent, a sift down reads the left child, reads the right child and
// compares, with setup states before the walk and a result readout after it. A query
// or a rejected operation goes straight to the result readout. After reset the position
// table is cleared one entry per cycle, and no transaction is accepted until it is done.
module indexed_min_heap_queue
    import imhq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // Heap entries and the position table.
    entry_t           entry_mem [CAPACITY];
    logic [CNT_W-1:0] pos_mem   [HANDLES];

    logic                 ent_we;
    logic [SLOT_W-1:0]    ent_waddr;
    entry_t               ent_wdata;
    logic [SLOT_W-1:0]    ent_raddr;
    entry_t               ent_rd_reg;

    logic                 pos_we;
    logic [HANDLE_W-1:0]  pos_waddr;
    logic [CNT_W-1:0]     pos_wdata;
    logic [HANDLE_W-1:0]  pos_raddr;
    logic [CNT_W-1:0]     pos_rd_reg;

    state_t               state_reg, state_next;
    logic [HANDLE_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    func_t                op_reg, op_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    status_t              status_reg, status_next;
    logic [SLOT_W-1:0]    hole_reg, hole_next;
    logic [SLOT_W-1:0]    pidx_reg, pidx_next;
    logic [KEY_BITS-1:0]  cur_key_reg, cur_key_next;
    logic [HANDLE_W-1:0]  cur_own_reg, cur_own_next;
    logic [KEY_BITS-1:0]  old_key_reg, old_key_next;
    logic [HANDLE_W-1:0]  del_own_reg, del_own_next;
    logic                 moved_reg, moved_next;
    entry_t               left_reg, left_next;
    logic                 left_less_reg, left_less_next;
    logic                 have_r_reg, have_r_next;

    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg, m_data_next;

    logic [CHILD_W-1:0]   lchild;
    logic [CHILD_W-1:0]   rchild;
    logic [CHILD_W-1:0]   count_ext;
    logic [KEY_BITS-1:0]  best_key;
    logic                 take_right;

    // Child indexes of the current hole, wide enough to hold the first index past the end.
    assign lchild    = {1'b0, hole_reg, 1'b1};
    assign rchild    = lchild + CHILD_W'(1);
    assign count_ext = CHILD_W'(count_reg);

    // Smaller of the current key and the left child, then the right child against that.
    assign best_key   = left_less_reg ? left_reg.key : cur_key_reg;
    assign take_right = have_r_reg && (ent_rd_reg.key < best_key);

    // Entry memory: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        ent_rd_reg <= entry_mem[ent_raddr];
    end

    // Position table: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        slot_reg      <= slot_next;
        handle_reg    <= handle_next;
        status_reg    <= status_next;
        hole_reg      <= hole_next;
        pidx_reg      <= pidx_next;
        cur_key_reg   <= cur_key_next;
        cur_own_reg   <= cur_own_next;
        old_key_reg   <= old_key_next;
        del_own_reg   <= del_own_next;
        moved_reg     <= moved_next;
        left_reg      <= left_next;
        left_less_reg <= left_less_next;
        have_r_reg    <= have_r_next;
        m_data_reg    <= m_data_next;
    end

    // Next state, memory control and result formation.
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        handle_next    = handle_reg;
        status_next    = status_reg;
        hole_next      = hole_reg;
        pidx_next      = pidx_reg;
        cur_key_next   = cur_key_reg;
        cur_own_next   = cur_own_reg;
        old_key_next   = old_key_reg;
        del_own_next   = del_own_reg;
        moved_next     = moved_reg;
        left_next      = left_reg;
        left_less_next = left_less_reg;
        have_r_next    = have_r_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        s_ready   = 1'b0;
        ent_we    = 1'b0;
        ent_waddr = hole_reg;
        ent_wdata = '{key: cur_key_reg, owner: cur_own_reg};
        ent_raddr = '0;
        pos_we    = 1'b0;
        pos_waddr = cur_own_reg;
        pos_wdata = CNT_W'(hole_reg);
        pos_raddr = handle_reg;

        case (state_reg)
            // Mark every handle as absent from the heap.
            S_CLEAR: begin
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = NOT_IN_HEAP;
                clr_next  = clr_reg + HANDLE_W'(1);
                if (clr_reg == HANDLE_W'(HANDLES - 1)) begin
                    state_next = S_IDLE;
                end
            end

            // Take a transaction and check it against the fill count.
            S_IDLE: begin
                s_ready   = 1'b1;
                ent_raddr = s_data.slot;
                if (s_valid) begin
                    op_next     = s_data.func;
                    slot_next   = s_data.slot;
                    handle_next = s_data.handle;
                    status_next = ST_OK;
                    moved_next  = 1'b0;
                    case (s_data.func)
                        FUNC_INSERT: begin
                            if (count_reg == NOT_IN_HEAP) begin
                                status_next = ST_FULL;
                                state_next  = S_RD_OUT;
                            end else begin
                                hole_next    = count_reg[SLOT_W-1:0];
                                cur_key_next = s_data.new_key;
                                cur_own_next = s_data.handle;
                                old_key_next = KEY_INF;
                                count_next   = count_reg + CNT_W'(1);
                                state_next   = S_DECIDE;
                            end
                        end
                        FUNC_DELETE, FUNC_CHANGE: begin
                            if (CNT_W'(s_data.slot) >= count_reg) begin
                                status_next = ST_BAD_SLOT;
                                state_next  = S_RD_OUT;
                            end else begin
                                cur_key_next = s_data.new_key;
                                state_next   = S_RD_A;
                            end
                        end
                        default: begin
                            state_next = S_RD_OUT;
                        end
                    endcase
                end
            end

            // The addressed entry is read; a delete also fetches the last entry.
            S_RD_A: begin
                old_key_next = ent_rd_reg.key;
                hole_next    = slot_reg;
                if (op_reg == FUNC_DELETE) begin
                    del_own_next = ent_rd_reg.owner;
                    pos_we       = 1'b1;
                    pos_waddr    = ent_rd_reg.owner;
                    pos_wdata    = NOT_IN_HEAP;
                    ent_raddr    = SLOT_W'(count_reg - CNT_W'(1));
                    state_next   = S_RD_B;
                end else begin
                    cur_own_next = ent_rd_reg.owner;
                    state_next   = S_DECIDE;
                end
            end

            // The last entry moves into the freed slot unless it was that slot.
            S_RD_B: begin
                cur_key_next = ent_rd_reg.key;
                cur_own_next = ent_rd_reg.owner;
                count_next   = count_reg - CNT_W'(1);
                if (CNT_W'(slot_reg) == count_reg - CNT_W'(1)) begin
                    state_next = S_RD_OUT;
                end else begin
                    state_next = S_DECIDE;
                end
            end

            // Pick the direction of the sift from the old and new keys.
            S_DECIDE: begin
                if (cur_key_reg > old_key_reg) begin
                    state_next = S_DN_RDL;
                end else if (cur_key_reg < old_key_reg) begin
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_PLACE;
                end
            end

            // Sift up: read the parent of the hole.
            S_UP_RD: begin
                pidx_next = (hole_reg - SLOT_W'(1)) >> 1;
                ent_raddr = (hole_reg - SLOT_W'(1)) >> 1;
                if (hole_reg == '0) begin
                    state_next = S_PLACE;
                end else begin
                    state_next = S_UP_CMP;
                end
            end

            // Sift up: a larger parent moves down into the hole.
            S_UP_CMP: begin
                if (ent_rd_reg.key > cur_key_reg) begin
                    ent_we     = 1'b1;
                    ent_wdata  = ent_rd_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = ent_rd_reg.owner;
                    hole_next  = pidx_reg;
                    moved_next = 1'b1;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_PLACE;
                end
            end

            // Sift down: read the left child if it exists.
            S_DN_RDL: begin
                ent_raddr = lchild[SLOT_W-1:0];
                if (lchild >= count_ext) begin
                    state_next = S_PLACE;
                end else begin
                    state_next = S_DN_RDR;
                end
            end

            // Sift down: keep the left child and read the right one.
            S_DN_RDR: begin
                left_next      = ent_rd_reg;
                left_less_next = ent_rd_reg.key < cur_key_reg;
                have_r_next    = rchild < count_ext;
                ent_raddr      = rchild[SLOT_W-1:0];
                state_next     = S_DN_CMP;
            end

            // Sift down: the smallest child moves up into the hole.
            S_DN_CMP: begin
                if (take_right) begin
                    ent_we     = 1'b1;
                    ent_wdata  = ent_rd_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = ent_rd_reg.owner;
                    hole_next  = rchild[SLOT_W-1:0];
                    moved_next = 1'b1;
                    state_next = S_DN_RDL;
                end else if (left_less_reg) begin
                    ent_we     = 1'b1;
                    ent_wdata  = left_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = left_reg.owner;
                    hole_next  = lchild[SLOT_W-1:0];
                    moved_next = 1'b1;
                    state_next = S_DN_RDL;
                end else begin
                    state_next = S_PLACE;
                end
            end

            // Write the carried entry into the hole. Its position is recorded when it
            // moved, when it is new, or when a delete left a different owner there.
            S_PLACE: begin
                ent_we = 1'b1;
                pos_we = moved_reg || (op_reg == FUNC_INSERT) ||
                         ((op_reg == FUNC_DELETE) && (cur_own_reg != del_own_reg));
                state_next = S_RD_OUT;
            end

            // Read the root and the handle's slot.
            S_RD_OUT: begin
                state_next = S_OUT;
            end

            // Hand the result to the output register once it is free.
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = status_reg;
                    m_data_next.entry_count = count_reg;
                    m_data_next.handle_slot = pos_rd_reg;
                    if (count_reg != '0) begin
                        m_data_next.min_key    = ent_rd_reg.key;
                        m_data_next.min_handle = ent_rd_reg.owner;
                    end else begin
                        m_data_next.min_key    = KEY_INF;
                        m_data_next.min_handle = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The fill count never passes the capacity.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NOT_IN_HEAP)
        else $error("entry count above capacity");

    // A full report only comes with a full heap.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_FULL) |-> m_data.entry_count == NOT_IN_HEAP)
        else $error("heap full reported below capacity");

    // The hole being sifted up always lies inside the heap.
    a_hole_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UP_CMP) |-> (CNT_W'(hole_reg) < count_reg))
        else $error("sift hole outside the heap");

    // A new result is loaded only after the last one was taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("pending result overwritten");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the indexed min-heap queue with a built-in heap predictor.
module tb_top
    import imhq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    indexed_min_heap_queue DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Predictor state: a shadow heap and position table.
    logic [KEY_BITS-1:0] heap_key [CAPACITY];
    logic [HANDLE_W-1:0] heap_owner [CAPACITY];
    logic [CNT_W-1:0]    owner_slot [HANDLES];
    int                  heap_fill;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int        error_count;
    int        stall_cycles;
    bit        no_idle;
    bit        hold_sender;
    bit        stim_done;

    // Acceptance flag captured at the rising edge, used by the driver.
    logic s_ready_seen;

    // Append one transaction to the stimulus queue.
    function automatic void add_pending(in_item_t it);
        pending_items = {pending_items, it};
    endfunction

    // The test handle space fills the whole table, so every handle is tracked.
    function automatic void place_entry(int s);
        owner_slot[heap_owner[s]] = CNT_W'(s);
    endfunction

    function automatic void swap_entries(int a, int b);
        logic [KEY_BITS-1:0] k;
        logic [HANDLE_W-1:0] o;
        k = heap_key[a];   o = heap_owner[a];
        heap_key[a] = heap_key[b];   heap_owner[a] = heap_owner[b];
        heap_key[b] = k;   heap_owner[b] = o;
        place_entry(a);
        place_entry(b);
    endfunction

    function automatic void sink(int i);
        int l, r, m;
        forever begin
            l = 2 * i + 1;
            r = l + 1;
            m = i;
            if (l < heap_fill && heap_key[l] < heap_key[i]) m = l;
            if (r < heap_fill && heap_key[r] < heap_key[m]) m = r;
            if (m == i) break;
            swap_entries(i, m);
            i = m;
        end
    endfunction

    function automatic void rise(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!(heap_key[p] > heap_key[i])) break;
            swap_entries(i, p);
            i = p;
        end
    endfunction

    function automatic void rekey(int i, logic [KEY_BITS-1:0] k);
        if (k > heap_key[i]) begin
            heap_key[i] = k;
            sink(i);
        end else if (k < heap_key[i]) begin
            heap_key[i] = k;
            rise(i);
        end
    endfunction

    // Apply one operation to the shadow heap and return the expected result.
    function automatic out_item_t predict_heap_op(in_item_t it);
        out_item_t r;
        int last;
        logic [KEY_BITS-1:0] moved;
        r = '0;
        r.status = ST_OK;
        case (it.func)
            FUNC_INSERT: begin
                if (heap_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    heap_key[heap_fill] = KEY_INF;
                    heap_owner[heap_fill] = it.handle;
                    place_entry(heap_fill);
                    heap_fill++;
                    rekey(heap_fill - 1, it.new_key);
                end
            end
            FUNC_DELETE: begin
                if (int'(it.slot) >= heap_fill) begin
                    r.status = ST_BAD_SLOT;
                end else begin
                    last = heap_fill - 1;
                    moved = heap_key[last];
                    owner_slot[heap_owner[last]] = CNT_W'(it.slot);
                    owner_slot[heap_owner[it.slot]] = NOT_IN_HEAP;
                    heap_owner[it.slot] = heap_owner[last];
                    heap_fill--;
                    if (int'(it.slot) != heap_fill) rekey(it.slot, moved);
                end
            end
            FUNC_CHANGE: begin
                if (int'(it.slot) >= heap_fill) r.status = ST_BAD_SLOT;
                else rekey(it.slot, it.new_key);
            end
            default: ;
        endcase
        r.min_key     = (heap_fill > 0) ? heap_key[0] : KEY_INF;
        r.min_handle  = (heap_fill > 0) ? heap_owner[0] : '0;
        r.entry_count = CNT_W'(heap_fill);
        r.handle_slot = owner_slot[it.handle];
        return r;
    endfunction

    function automatic in_item_t make_op(func_t f, int s, logic [31:0] k, int h);
        in_item_t it;
        it.func = f;
        it.slot = SLOT_W'(s);
        it.new_key = k;
        it.handle = HANDLE_W'(h);
        return it;
    endfunction

    function automatic logic [31:0] random_key();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return KEY_INF;
            2: return 32'(($urandom_range(0, 15)) << 16);
            default: return $urandom();
        endcase
    endfunction

    // Slot choice: mostly valid slots, sometimes past the end of the heap.
    function automatic int random_slot(int fill);
        if (fill == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
        return $urandom_range(0, fill - 1);
    endfunction

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Stimulus: directed operations, a fill to capacity, then random mixes.
    initial begin
        int fill;
        int n;
        int op;
        aresetn = 1'b0;
        hold_sender = 1'b0;
        stim_done = 1'b0;
        no_idle = 1'b0;
        // Directed part on a small heap; fill tracks the expected count.
        add_pending(make_op(FUNC_QUERY, 0, 32'h0, 1023));
        add_pending(make_op(FUNC_DELETE, 0, 32'h0, 0));
        add_pending(make_op(FUNC_CHANGE, 1023, 32'hFFFF_FFFF, 0));
        add_pending(make_op(FUNC_INSERT, 0, 32'h0005_0000, 5));
        add_pending(make_op(FUNC_INSERT, 0, KEY_INF, 1023));
        add_pending(make_op(FUNC_INSERT, 0, 32'h0, 0));
        add_pending(make_op(FUNC_INSERT, 0, 32'h0005_0000, 5));
        add_pending(make_op(FUNC_INSERT, 1023, 32'h0001_8000, 682));
        add_pending(make_op(FUNC_CHANGE, 1, 32'h0001_8000, 341));
        add_pending(make_op(FUNC_CHANGE, 2, 32'h0000_0001, 5));
        add_pending(make_op(FUNC_CHANGE, 0, 32'hFFFF_FFFE, 0));
        add_pending(make_op(FUNC_QUERY, 1023, 32'hAAAA_5555, 5));
        add_pending(make_op(FUNC_DELETE, 4, 32'h0, 682));
        add_pending(make_op(FUNC_DELETE, 0, 32'h0, 0));
        add_pending(make_op(FUNC_DELETE, 5, 32'h0, 5));
        add_pending(make_op(FUNC_DELETE, 1, 32'h0, 1023));
        fill = 2;
        // Fill to capacity with random keys, hit the full case, then query once.
        for (int i = 0; i < CAPACITY - fill; i++)
            add_pending(make_op(FUNC_INSERT, $urandom_range(0, 1023),
                                random_key(), $urandom_range(0, 1023)));
        fill = CAPACITY;
        add_pending(make_op(FUNC_INSERT, 0, 32'h0, 77));
        add_pending(make_op(FUNC_QUERY, 0, 32'h0, 77));
        // Pre-filled items are consumed before the random mix begins.
        wait (aresetn);
        // Pause the sender until the heap work so far is fully checked.
        wait (pending_items.size() == 0);
        hold_sender = 1'b1;
        wait (!s_valid && expected_results.size() == 0);
        repeat (50) @(posedge aclk);
        hold_sender = 1'b0;
        // Random mix, alternating every 20 operations between delete-heavy and insert-heavy weights.
        for (int i = 0; i < 60; i++) begin
            op = $urandom_range(0, 99);
            if (i == 10) no_idle = 1'b1;
            if (i == 50) no_idle = 1'b0;
            if (op < ((i / 20) % 2 == 0 ? 25 : 55)) begin
                add_pending(make_op(FUNC_INSERT, $urandom_range(0, 1023),
                                    random_key(), $urandom_range(0, 1023)));
                if (fill < CAPACITY) fill++;
            end else if (op < ((i / 20) % 2 == 0 ? 60 : 70)) begin
                n = random_slot(fill);
                add_pending(make_op(FUNC_DELETE, n, random_key(),
                                    $urandom_range(0, 1023)));
                if (n < fill) fill--;
            end else if (op < 90) begin
                add_pending(make_op(FUNC_CHANGE, random_slot(fill), random_key(),
                                    $urandom_range(0, 1023)));
            end else begin
                add_pending(make_op(FUNC_QUERY, $urandom_range(0, 1023),
                                    $urandom(), $urandom_range(0, 1023)));
            end
            while (pending_items.size() > 8) @(posedge aclk);
        end
        stim_done = 1'b1;
    end

    // Reset sequence.
    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Driver: presents pending transactions at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_ready_seen) begin
                if (pending_items.size() > 0 && !hold_sender &&
                    (no_idle || $urandom_range(0, 99) >= 18)) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= no_idle || ($urandom_range(0, 99) >= 18);
        end
    end

    // Monitor: predicts accepted inputs and checks accepted results.
    always @(posedge aclk) begin
        out_item_t exp_r;
        s_ready_seen <= s_valid && s_ready;
        if (!aresetn) begin
            heap_fill = 0;
            for (int i = 0; i < HANDLES; i++) owner_slot[i] = NOT_IN_HEAP;
        end else begin
            if (s_valid && s_ready)
                expected_results = {expected_results, predict_heap_op(s_data)};
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %p", $realtime, m_data);
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_data.status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, exp_r.status, m_data.status);
                        error_count++;
                    end
                    if (m_data.min_key !== exp_r.min_key) begin
                        $display("%0t: min_key expected %h actual %h",
                                 $realtime, exp_r.min_key, m_data.min_key);
                        error_count++;
                    end
                    if (m_data.min_handle !== exp_r.min_handle) begin
                        $display("%0t: min_handle expected %0d actual %0d",
                                 $realtime, exp_r.min_handle, m_data.min_handle);
                        error_count++;
                    end
                    if (m_data.entry_count !== exp_r.entry_count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $realtime, exp_r.entry_count, m_data.entry_count);
                        error_count++;
                    end
                    if (m_data.handle_slot !== exp_r.handle_slot) begin
                        $display("%0t: handle_slot expected %0d actual %0d",
                                 $realtime, exp_r.handle_slot, m_data.handle_slot);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transaction, and the end of the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 5000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        wait (pending_items.size() == 0 && !s_valid && expected_results.size() == 0);
        repeat (100) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
